FILE: hw/rtl/linear_probe_hash_table_macros.svh
// Assertion helpers for the hash table RTL. They expand to nothing in synthesis.
`ifndef LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_MACROS_SVH

`ifndef SYNTHESIS
`define LPHT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hash table assertion failed");
`define LPHT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hash table assertion failed");
`else
`define LPHT_ASSERT_IMP(lbl, ante, cons)
`define LPHT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: hw/rtl/lpht_pkg.sv
package lpht_pkg;

    localparam int TABLE_SLOTS = 1024;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int KEY_W       = 64;
    localparam int VAL_W       = 8;
    localparam int COUNT_W     = 11;

    localparam logic [63:0] MIX_MUL_A = 64'hff51afd7ed558ccd;
    localparam logic [63:0] MIX_MUL_B = 64'hc4ceb9fe1a85ec53;
    localparam int          MIX_SHIFT = 33;
    localparam int          LOAD_NUM  = 7;
    localparam int          LOAD_DEN  = 10;
    // An insert of a new key is refused once the entry count reaches this.
    localparam int          LOAD_LIMIT = (TABLE_SLOTS * LOAD_NUM) / LOAD_DEN;

    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_WRITE  = 2'd2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_ABSENT   = 2'd1;
    localparam logic [1:0] STATUS_FULL     = 2'd2;
    localparam logic [1:0] STATUS_ZERO_KEY = 2'd3;

    typedef struct packed {
        logic             start;
        logic [KEY_W-1:0] key;
    } mix_req_t;

    typedef struct packed {
        logic              done;
        logic [SLOT_W-1:0] home;
    } mix_rsp_t;

    function automatic logic [63:0] xor_shift(input logic [63:0] v);
        return v ^ (v >> MIX_SHIFT);
    endfunction

endpackage

FILE: hw/rtl/lpht_mix.sv
// Iterative fmix64 mixer built around one 32x32 multiplier. Each 64-bit
// multiply (low half of the product) takes three partial products.
module lpht_mix
    import lpht_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mix_req_t req,
    output mix_rsp_t rsp
);

    typedef enum logic [4:0] {
        MX_IDLE = 5'b00001,
        MX_MUL0 = 5'b00010,
        MX_MUL1 = 5'b00100,
        MX_MUL2 = 5'b01000,
        MX_ACC  = 5'b10000
    } mx_state_t;

    mx_state_t   state_reg, state_next;
    logic        round_reg, round_next;
    logic        done_reg, done_next;
    logic [63:0] v_reg, v_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] prod_reg, prod_next;
    logic [63:0] mul_const;
    logic [31:0] mul_a, mul_b;
    logic [31:0] acc_hi_sum;

    assign mul_const = round_reg ? MIX_MUL_B : MIX_MUL_A;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = v_reg[31:0];
        mul_b = mul_const[31:0];
        case (state_reg)
            MX_MUL1:
            begin
                mul_b = mul_const[63:32];
            end
            MX_MUL2:
            begin
                mul_a = v_reg[63:32];
            end
            default:
            begin
                mul_a = v_reg[31:0];
                mul_b = mul_const[31:0];
            end
        endcase
    end

    assign prod_next  = 64'(mul_a) * 64'(mul_b);
    assign acc_hi_sum = acc_reg[63:32] + prod_reg[31:0];

    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        done_next  = 1'b0;
        v_next     = v_reg;
        acc_next   = acc_reg;
        case (state_reg)
            MX_IDLE:
            begin
                if (req.start)
                begin
                    v_next     = xor_shift(req.key);
                    round_next = 1'b0;
                    state_next = MX_MUL0;
                end
            end
            MX_MUL0:
            begin
                state_next = MX_MUL1;
            end
            MX_MUL1:
            begin
                acc_next   = prod_reg;
                state_next = MX_MUL2;
            end
            MX_MUL2:
            begin
                acc_next   = {acc_hi_sum, acc_reg[31:0]};
                state_next = MX_ACC;
            end
            MX_ACC:
            begin
                v_next = xor_shift({acc_hi_sum, acc_reg[31:0]});
                if (round_reg)
                begin
                    done_next  = 1'b1;
                    state_next = MX_IDLE;
                end
                else
                begin
                    round_next = 1'b1;
                    state_next = MX_MUL0;
                end
            end
            default:
            begin
                state_next = MX_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MX_IDLE;
            round_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg    <= v_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
    end

    assign rsp.done = done_reg;
    assign rsp.home = v_reg[SLOT_W-1:0];

endmodule

FILE: hw/rtl/linear_probe_hash_table.sv
// Open-addressed key/value table of 1024 slots with linear probing. Each
// input word is a lookup, an insert (new keys get value zero) or a value
// write to a present key; each produces exactly one result word with the
// status, the slot and value of the key, and the largest key inserted so
// far. Key zero is reported as invalid and changes nothing. Inserts of new
// keys are refused with status full once 716 entries (70%) are in use.
// After reset the key store is cleared by a pass over all 1024 slots,
// during which in_stall stays high. An operation runs the home-slot
// mixer and then probes slots one per cycle through the key memory's
// read port; the mixer runs two 64-bit multiplies as three passes each
// through one 32x32 multiplier. A zero key skips the mixer and the probe.
// The block takes one word at a time; a finished result may wait in the
// output register while the next word is accepted and processed.
module linear_probe_hash_table
    import lpht_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        mode,
    input  logic [KEY_W-1:0]  key,
    input  logic [VAL_W-1:0]  new_value,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status,
    output logic              was_present,
    output logic [VAL_W-1:0]  stored_value,
    output logic [SLOT_W-1:0] slot_index,
    output logic [KEY_W-1:0]  max_key
);

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_HASH   = 6'b000100,
        ST_READ   = 6'b001000,
        ST_CHECK  = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Control state.
    logic [SLOT_W-1:0]  clr_reg, clr_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [KEY_W-1:0]   largest_reg, largest_next;
    logic               out_valid_reg, out_valid_next;

    // Current operation and its result.
    logic [1:0]        op_mode_reg, op_mode_next;
    logic [KEY_W-1:0]  op_key_reg, op_key_next;
    logic [VAL_W-1:0]  op_val_reg, op_val_next;
    logic [SLOT_W-1:0] pos_reg, pos_next;
    logic [1:0]        res_status_reg, res_status_next;
    logic              res_present_reg, res_present_next;
    logic [VAL_W-1:0]  res_value_reg, res_value_next;
    logic [SLOT_W-1:0] res_slot_reg, res_slot_next;

    // Output register.
    logic [1:0]        out_status_reg;
    logic              out_present_reg;
    logic [VAL_W-1:0]  out_value_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic [KEY_W-1:0]  out_max_reg;
    logic              out_load;

    // Memories and their ports.
    logic [KEY_W-1:0]  key_mem [TABLE_SLOTS];
    logic [VAL_W-1:0]  val_mem [TABLE_SLOTS];
    logic [KEY_W-1:0]  key_rd_reg;
    logic [VAL_W-1:0]  val_rd_reg;
    logic              key_we, val_we;
    logic [SLOT_W-1:0] key_waddr, rd_addr;
    logic [KEY_W-1:0]  key_wdata;
    logic [VAL_W-1:0]  val_wdata;
    logic [SLOT_W-1:0] pos_inc;

    mix_req_t mix_req;
    mix_rsp_t mix_rsp;

    logic in_fire;

    lpht_mix u_mix (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mix_req),
        .rsp   (mix_rsp)
    );

    assign in_stall = (state_reg != ST_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign pos_inc  = pos_reg + SLOT_W'(1);

    assign mix_req.start = in_fire && (key != '0);
    assign mix_req.key   = key;

    // The output register may be refilled in the same cycle it is taken.
    assign out_load = (state_reg == ST_FINISH) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next       = state_reg;
        clr_next         = clr_reg;
        count_next       = count_reg;
        largest_next     = largest_reg;
        op_mode_next     = op_mode_reg;
        op_key_next      = op_key_reg;
        op_val_next      = op_val_reg;
        pos_next         = pos_reg;
        res_status_next  = res_status_reg;
        res_present_next = res_present_reg;
        res_value_next   = res_value_reg;
        res_slot_next    = res_slot_reg;
        key_we           = 1'b0;
        val_we           = 1'b0;
        key_waddr        = pos_reg;
        key_wdata        = op_key_reg;
        val_wdata        = '0;
        rd_addr          = pos_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                key_we    = 1'b1;
                key_waddr = clr_reg;
                key_wdata = '0;
                clr_next  = clr_reg + SLOT_W'(1);
                if (clr_reg == SLOT_W'(TABLE_SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    op_mode_next     = mode;
                    op_key_next      = key;
                    op_val_next      = new_value;
                    res_present_next = 1'b0;
                    res_value_next   = '0;
                    res_slot_next    = '0;
                    res_status_next  = STATUS_ZERO_KEY;
                    if (key == '0)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_HASH;
                    end
                end
            end
            ST_HASH:
            begin
                if (mix_rsp.done)
                begin
                    pos_next   = mix_rsp.home;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (key_rd_reg == '0)
                begin
                    // Empty slot reached: the key is absent.
                    if (op_mode_reg == MODE_INSERT)
                    begin
                        if (count_reg >= COUNT_W'(LOAD_LIMIT))
                        begin
                            res_status_next = STATUS_FULL;
                        end
                        else
                        begin
                            key_we          = 1'b1;
                            val_we          = 1'b1;
                            val_wdata       = '0;
                            count_next      = count_reg + COUNT_W'(1);
                            res_status_next = STATUS_OK;
                            res_slot_next   = pos_reg;
                            if (op_key_reg > largest_reg)
                            begin
                                largest_next = op_key_reg;
                            end
                        end
                    end
                    else
                    begin
                        res_status_next = STATUS_ABSENT;
                    end
                    state_next = ST_FINISH;
                end
                else if (key_rd_reg == op_key_reg)
                begin
                    res_status_next  = STATUS_OK;
                    res_present_next = 1'b1;
                    res_slot_next    = pos_reg;
                    if (op_mode_reg == MODE_WRITE)
                    begin
                        val_we         = 1'b1;
                        val_wdata      = op_val_reg;
                        res_value_next = op_val_reg;
                    end
                    else
                    begin
                        res_value_next = val_rd_reg;
                    end
                    state_next = ST_FINISH;
                end
                else
                begin
                    // Occupied by another key: read the next slot right away.
                    rd_addr  = pos_inc;
                    pos_next = pos_inc;
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            count_reg     <= '0;
            largest_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            largest_reg   <= largest_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_mode_reg     <= op_mode_next;
        op_key_reg      <= op_key_next;
        op_val_reg      <= op_val_next;
        pos_reg         <= pos_next;
        res_status_reg  <= res_status_next;
        res_present_reg <= res_present_next;
        res_value_reg   <= res_value_next;
        res_slot_reg    <= res_slot_next;
        if (out_load)
        begin
            out_status_reg  <= res_status_reg;
            out_present_reg <= res_present_reg;
            out_value_reg   <= res_value_reg;
            out_slot_reg    <= res_slot_reg;
            out_max_reg     <= largest_reg;
        end
    end

    // Key and value memories: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_waddr] <= key_wdata;
        end
        key_rd_reg <= key_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[pos_reg] <= val_wdata;
        end
        val_rd_reg <= val_mem[rd_addr];
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign was_present  = out_present_reg;
    assign stored_value = out_value_reg;
    assign slot_index   = out_slot_reg;
    assign max_key      = out_max_reg;

`include "linear_probe_hash_table_macros.svh"

    // The entry count never passes the load limit.
    `LPHT_ASSERT_IMP(a_count_limit, 1'b1, count_reg <= COUNT_W'(LOAD_LIMIT))
    // The largest inserted key never decreases.
    `LPHT_ASSERT_NEXT(a_largest_mono, 1'b1, largest_reg >= $past(largest_reg))
    // An accepted word keeps the block busy in the following cycle.
    `LPHT_ASSERT_NEXT(a_busy_after_accept, in_fire, in_stall)
    // The mixer reports a home slot only while an operation waits for it.
    `LPHT_ASSERT_IMP(a_mix_done_in_hash, mix_rsp.done, state_reg == ST_HASH)

endmodule
